/* rtl/core/pfcu_pkg.sv */
// ----------------------------------------------------------------------------
// pfcu_pkg
// Shared types and constants of the projected factor column update unit.
// ----------------------------------------------------------------------------
package pfcu_pkg;

	localparam int MAX_ROWS     = 64;
	localparam int MAX_FEATURES = 64;
	localparam int MAX_RANK     = 8;
	localparam int ROW_BITS     = $clog2(MAX_ROWS);
	localparam int FEAT_BITS    = $clog2(MAX_FEATURES);
	localparam int RANK_BITS    = $clog2(MAX_RANK);

	localparam logic [2:0] REQ_LOAD_V = 3'd0;
	localparam logic [2:0] REQ_LOAD_X = 3'd1;
	localparam logic [2:0] REQ_LOAD_U = 3'd2;
	localparam logic [2:0] REQ_RUN    = 3'd3;
	localparam logic [2:0] REQ_READ_U = 3'd4;

	localparam logic [2:0] CFG_SWEEPS   = 3'd0;
	localparam logic [2:0] CFG_NONNEG   = 3'd1;
	localparam logic [2:0] CFG_ROWS     = 3'd2;
	localparam logic [2:0] CFG_FEATURES = 3'd3;
	localparam logic [2:0] CFG_RANK     = 3'd4;

	localparam logic RESULT_RUN  = 1'b0;
	localparam logic RESULT_READ = 1'b1;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [31:0] element_value;
	} req_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] factor_value;
		logic               saturated;
	} rsp_t;

	// Floor of (x + 2^15) / 2^16 on a 64-bit signed value.
	function automatic logic signed [63:0] round_q16(input logic signed [63:0] x);
		logic signed [63:0] t;
		begin
			t = x + 64'sd32768;
			return t >>> 16;
		end
	endfunction

endpackage

/* rtl/core/pfcu_if.sv */
// ----------------------------------------------------------------------------
// pfcu_req_if / pfcu_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface pfcu_req_if;
	logic          valid;
	logic          ready;
	pfcu_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pfcu_rsp_if;
	logic          valid;
	logic          ready;
	pfcu_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/pfcu_divider.sv */
// ----------------------------------------------------------------------------
// pfcu_divider
// Radix-2 restoring divider for unsigned 64-bit by 64-bit, one bit a cycle.
// ----------------------------------------------------------------------------
module pfcu_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

/* rtl/core/projected_factor_column_update_unit.sv */
// ----------------------------------------------------------------------------
// projected_factor_column_update_unit
// Projected block-coordinate update of a factor matrix U from X and V.
// ----------------------------------------------------------------------------
// Requests arrive on req: element loads of V, X and U, a run command and U
// reads. Loads give no result, so they stream one a cycle while the result
// register is free. A read gives one result, raised from ST_RD_D after ST_RD,
// and holds the request channel until the unit is back in idle. A run forms
// XV and the Gram matrix with one multiplier over the stores, then sweeps the
// columns; every division goes through a shared bit-serial unit, and each
// column whose squared norm exceeds one is divided by its norm. The run
// result is raised from ST_DONE after the last sweep, or after the Gram matrix
// when the sweep count is zero. Results wait in the output register while the
// receiver stalls, and no new request is taken until it drains.
// Reset returns registers to their reset values and clears the saturation
// flag; store contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module projected_factor_column_update_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	pfcu_req_if.sink    req,
	pfcu_rsp_if.source  rsp
);
	localparam int RB = pfcu_pkg::ROW_BITS;
	localparam int FB = pfcu_pkg::FEAT_BITS;
	localparam int KB = pfcu_pkg::RANK_BITS;

	localparam logic [4:0] ST_IDLE = 5'd0, ST_RD = 5'd1, ST_XV_A = 5'd2, ST_XV_M = 5'd3,
		ST_XV_W = 5'd4, ST_G_A = 5'd5, ST_G_M = 5'd6, ST_G_W = 5'd7, ST_CK = 5'd8,
		ST_CK_D = 5'd9, ST_R_A = 5'd10, ST_R_M = 5'd11, ST_R_N = 5'd12, ST_D_S = 5'd13,
		ST_D_W = 5'd14, ST_D_U = 5'd15, ST_NORM = 5'd16, ST_SQ = 5'd17, ST_P_A = 5'd18,
		ST_P_S = 5'd19, ST_P_W = 5'd20, ST_NEXT = 5'd21, ST_DONE = 5'd22, ST_RD_D = 5'd23,
		ST_R_X = 5'd24, ST_D_R = 5'd25;

	logic [4:0] st_q;
	logic [7:0] sweeps_q;
	logic       nonneg_q;
	logic [6:0] rows_q, feats_q;
	logic [3:0] rank_q;
	logic       sat_q;

	logic signed [31:0] v_mem [pfcu_pkg::MAX_FEATURES*pfcu_pkg::MAX_RANK];
	logic signed [31:0] x_mem [pfcu_pkg::MAX_ROWS*pfcu_pkg::MAX_FEATURES];
	logic signed [31:0] u_mem [pfcu_pkg::MAX_ROWS*pfcu_pkg::MAX_RANK];
	logic signed [31:0] xv_mem [pfcu_pkg::MAX_ROWS*pfcu_pkg::MAX_RANK];
	logic signed [31:0] g_mem [pfcu_pkg::MAX_RANK*pfcu_pkg::MAX_RANK];
	logic signed [46:0] cs_mem [pfcu_pkg::MAX_ROWS];

	logic signed [31:0] v_rd_a, v_rd_b, x_rd, u_rd, xv_rd, g_rd, g_rd2;
	logic signed [46:0] cs_rd;

	logic [RB-1:0] i_q;
	logic [FB-1:0] j_q;
	logic [KB-1:0] k_q, jj_q;
	logic [7:0]    sw_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic [63:0]   s_q;
	logic [5:0]    e_q;
	logic [63:0]   nrm_q;
	logic signed [31:0] unew_q;
	logic signed [31:0] gkk_q;
	logic          neg_q;

	logic [6:0] n_eff, p_eff;
	logic [3:0] r_eff;
	assign n_eff = (rows_q == 7'd0) ? 7'd1 : (rows_q > 7'd64 ? 7'd64 : rows_q);
	assign p_eff = (feats_q == 7'd0) ? 7'd1 : (feats_q > 7'd64 ? 7'd64 : feats_q);
	assign r_eff = (rank_q == 4'd0) ? 4'd1 : (rank_q > 4'd8 ? 4'd8 : rank_q);

	logic        div_start, div_done;
	logic [63:0] div_num, div_den, div_quot;
	pfcu_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(div_quot));

	// isqrt state
	logic [63:0] sq_x_q, sq_r_q, sq_b_q;

	logic rsp_free;
	assign rsp_free = !rsp.valid || rsp.ready;
	assign req.ready = (st_q == ST_IDLE) && rsp_free;
	logic acc_req;
	assign acc_req = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweeps_q <= 8'd5; nonneg_q <= 1'b0; rows_q <= 7'd64;
			feats_q <= 7'd64; rank_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfcu_pkg::CFG_SWEEPS:   sweeps_q <= cfg_data;
				pfcu_pkg::CFG_NONNEG:   nonneg_q <= cfg_data[0];
				pfcu_pkg::CFG_ROWS:     rows_q <= cfg_data[6:0];
				pfcu_pkg::CFG_FEATURES: feats_q <= cfg_data[6:0];
				pfcu_pkg::CFG_RANK:     rank_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Address generation for the stores.
	logic [RB-1:0] rd_row;
	logic [KB-1:0] rd_col;
	logic [KB-1:0] u_col;
	logic [KB-1:0] g_r, g_c;
	logic [FB-1:0] v_row;
	logic [KB-1:0] va_c, vb_c;

	always_comb begin
		u_col = jj_q;
		if (st_q == ST_D_S || st_q == ST_D_R || st_q == ST_D_U || st_q == ST_P_A ||
			st_q == ST_P_S || st_q == ST_P_W || st_q == ST_CK)
			u_col = k_q;
		g_r = jj_q; g_c = k_q;
		if (st_q == ST_CK) g_r = k_q;
		v_row = j_q;
		va_c = (st_q == ST_G_A) ? jj_q : k_q;
		vb_c = k_q;
		rd_row = i_q;
		rd_col = u_col;
	end

	// Store writes.
	logic          u_we;
	logic [RB-1:0] u_wrow;
	logic [KB-1:0] u_wcol;
	logic signed [31:0] u_wdata;
	logic          xv_we, g_we, cs_we;
	logic signed [31:0] sat_acc;
	logic          sat_hit;
	logic signed [31:0] p_val;

	always_comb begin
		sat_hit = 1'b0;
		if (acc_q > 64'sh7FFFFFFF) begin sat_acc = 32'sh7FFFFFFF; sat_hit = 1'b1; end
		else if (acc_q < -64'sh80000000) begin sat_acc = 32'sh80000000; sat_hit = 1'b1; end
		else sat_acc = acc_q[31:0];
	end

	always_comb begin
		u_we = 1'b0; u_wrow = i_q; u_wcol = k_q; u_wdata = unew_q;
		if (acc_req && req.payload.req_type == pfcu_pkg::REQ_LOAD_U &&
			req.payload.col_index < 6'(pfcu_pkg::MAX_RANK)) begin
			u_we = 1'b1;
			u_wrow = req.payload.row_index[RB-1:0];
			u_wcol = req.payload.col_index[KB-1:0];
			u_wdata = req.payload.element_value;
		end else if (st_q == ST_D_W) begin
			u_we = 1'b1;
		end else if (st_q == ST_P_W && div_done) begin
			u_we = 1'b1;
			u_wdata = p_val;
		end
		xv_we = (st_q == ST_XV_W);
		g_we = (st_q == ST_G_W);
		cs_we = (st_q == ST_R_X);
	end

	// Step arithmetic.
	logic signed [63:0] mul_a, mul_b;
	logic signed [63:0] resid_c;
	logic signed [63:0] step_s, u_sum;
	logic signed [31:0] u_sat;
	logic               u_sat_hit;
	logic [63:0] cs_mag;
	logic        last_i, last_j, last_k, last_jj;

	always_comb begin
		if (acc_q > 64'sh3FFFFFFFFFFF) resid_c = 64'sh3FFFFFFFFFFF;
		else if (acc_q < -64'sh400000000000) resid_c = -64'sh400000000000;
		else resid_c = acc_q;
	end

	always_ff @(posedge clk) begin
		if (acc_req && req.payload.req_type == pfcu_pkg::REQ_LOAD_V &&
			req.payload.col_index < 6'(pfcu_pkg::MAX_RANK))
			v_mem[{req.payload.row_index[FB-1:0], req.payload.col_index[KB-1:0]}] <=
				req.payload.element_value;
		if (acc_req && req.payload.req_type == pfcu_pkg::REQ_LOAD_X)
			x_mem[{req.payload.row_index[RB-1:0], req.payload.col_index[FB-1:0]}] <=
				req.payload.element_value;
		if (u_we) u_mem[{u_wrow, u_wcol}] <= u_wdata;
		if (xv_we) xv_mem[{i_q, k_q}] <= sat_acc;
		if (g_we) g_mem[{jj_q, k_q}] <= sat_acc;
		if (cs_we) cs_mem[i_q] <= resid_c[46:0];
		v_rd_a <= v_mem[{v_row, va_c}];
		v_rd_b <= v_mem[{v_row, vb_c}];
		x_rd <= x_mem[{i_q, j_q}];
		u_rd <= (acc_req) ? u_mem[{req.payload.row_index[RB-1:0],
			req.payload.col_index[KB-1:0]}] : u_mem[{rd_row, rd_col}];
		xv_rd <= xv_mem[{i_q, k_q}];
		g_rd <= g_mem[{g_r, g_c}];
		g_rd2 <= g_mem[{k_q, k_q}];
		cs_rd <= cs_mem[i_q];
	end

	assign last_i  = ({1'b0, i_q} == 7'(n_eff - 7'd1));
	assign last_j  = ({1'b0, j_q} == 7'(p_eff - 7'd1));
	assign last_k  = ({1'b0, k_q} == 4'(r_eff - 4'd1));
	assign last_jj = ({1'b0, jj_q} == 4'(r_eff - 4'd1));
	assign cs_mag  = cs_rd[46] ? 64'(-{{17{cs_rd[46]}}, cs_rd}) : 64'({17'd0, cs_rd});

	always_comb begin
		step_s = neg_q ? -$signed(div_quot) : $signed(div_quot);
		u_sum = 64'(u_rd) + step_s;
		u_sat_hit = 1'b0;
		if (u_sum > 64'sh7FFFFFFF) begin u_sat = 32'sh7FFFFFFF; u_sat_hit = 1'b1; end
		else if (u_sum < -64'sh80000000) begin u_sat = 32'sh80000000; u_sat_hit = 1'b1; end
		else u_sat = u_sum[31:0];
		mul_a = 64'(x_rd); mul_b = 64'(v_rd_b);
		if (st_q == ST_G_M) begin mul_a = 64'(v_rd_a); mul_b = 64'(v_rd_b); end
		else if (st_q == ST_R_M) begin mul_a = 64'(u_rd); mul_b = 64'(g_rd); end
	end

	// Projection step.
	logic [63:0] p_mag;
	logic        p_neg;
	assign p_neg = u_rd[31];
	assign p_mag = p_neg ? 64'(-64'(u_rd)) : 64'(u_rd);

	always_comb begin
		if (div_quot > 64'd2147483647 + 64'(p_neg))
			p_val = p_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			p_val = p_neg ? -div_quot[31:0] : div_quot[31:0];
	end

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = 64'(gkk_q);
		if (st_q == ST_D_S) begin
			div_start = 1'b1;
			div_num = (cs_mag << 16) + 64'(gkk_q[31:1]);
		end else if (st_q == ST_P_S) begin
			div_start = 1'b1;
			div_den = nrm_q;
			div_num = (p_mag << 16) + (nrm_q >> 1);
		end
	end

	logic [63:0] sq_t;
	assign sq_t = sq_r_q + sq_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			sat_q <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (acc_req) begin
						if (req.payload.req_type == pfcu_pkg::REQ_READ_U) begin
							st_q <= ST_RD;
						end else if (req.payload.req_type == pfcu_pkg::REQ_RUN) begin
							sat_q <= 1'b0;
							st_q <= ST_XV_A;
						end
					end
				end
				ST_RD: st_q <= ST_RD_D;
				ST_RD_D: begin
					rsp.valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_XV_A: st_q <= ST_XV_M;
				ST_XV_M: begin
					st_q <= last_j ? ST_XV_W : ST_XV_A;
				end
				ST_XV_W: begin
					if (sat_hit) sat_q <= 1'b1;
					if (last_k && last_i) st_q <= ST_G_A;
					else st_q <= ST_XV_A;
				end
				ST_G_A: st_q <= ST_G_M;
				ST_G_M: st_q <= last_j ? ST_G_W : ST_G_A;
				ST_G_W: begin
					if (sat_hit) sat_q <= 1'b1;
					if (last_k && last_jj) st_q <= (sweeps_q == 8'd0) ? ST_DONE : ST_CK;
					else st_q <= ST_G_A;
				end
				ST_CK: st_q <= ST_CK_D;
				ST_CK_D: st_q <= (g_rd2 > 32'sd0) ? ST_R_A : ST_NEXT;
				ST_R_A: st_q <= ST_R_M;
				ST_R_M: st_q <= ST_R_N;
				ST_R_N: st_q <= last_jj ? ST_R_X : ST_R_A;
				ST_R_X: begin
					if (resid_c != acc_q) sat_q <= 1'b1;
					st_q <= last_i ? ST_D_R : ST_R_A;
				end
				ST_D_R: st_q <= ST_D_S;
				ST_D_S: st_q <= ST_D_U;
				ST_D_U: if (div_done) begin
					if (u_sat_hit) sat_q <= 1'b1;
					st_q <= ST_D_W;
				end
				ST_D_W: st_q <= last_i ? ST_NORM : ST_D_R;
				ST_NORM: begin
					if (s_q > 64'd65536) st_q <= ST_SQ;
					else st_q <= ST_NEXT;
				end
				ST_SQ: if (sq_b_q == 64'd0) st_q <= ST_P_A;
				ST_P_A: st_q <= ST_P_S;
				ST_P_S: st_q <= ST_P_W;
				ST_P_W: begin
					if (div_done) begin
						if (div_quot > 64'd2147483647 + 64'(p_neg)) sat_q <= 1'b1;
						st_q <= last_i ? ST_NEXT : ST_P_A;
					end
				end
				ST_NEXT: begin
					if (last_k && sw_q == 8'(sweeps_q - 8'd1)) st_q <= ST_DONE;
					else st_q <= ST_CK;
				end
				ST_DONE: begin
					rsp.valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, indices and the result payload.
	logic signed [63:0] sq_term;
	assign sq_term = pfcu_pkg::round_q16(64'(unew_q) * 64'(unew_q));

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				i_q <= '0; j_q <= '0; k_q <= '0; jj_q <= '0; sw_q <= '0; acc_q <= '0;
				if (acc_req) begin
					rsp.payload.result_kind <= (req.payload.req_type == pfcu_pkg::REQ_READ_U)
						? pfcu_pkg::RESULT_READ : pfcu_pkg::RESULT_RUN;
					neg_q <= (req.payload.col_index < 6'(pfcu_pkg::MAX_RANK));
				end
			end
			ST_RD: begin
				rsp.payload.factor_value <= neg_q ? u_rd : 32'sd0;
				rsp.payload.saturated <= sat_q;
			end
			ST_RD_D: ;
			ST_XV_A, ST_G_A: ;
			ST_XV_M, ST_G_M: begin
				acc_q <= acc_q + pfcu_pkg::round_q16(mul_a * mul_b);
				if (!last_j) j_q <= j_q + 1'b1;
			end
			ST_XV_W: begin
				acc_q <= '0; j_q <= '0;
				if (last_k) begin k_q <= '0; i_q <= i_q + 1'b1; end
				else k_q <= k_q + 1'b1;
			end
			ST_G_W: begin
				acc_q <= '0; j_q <= '0;
				if (last_k) begin k_q <= '0; jj_q <= jj_q + 1'b1; end
				else k_q <= k_q + 1'b1;
				if (last_k && last_jj) begin jj_q <= '0; i_q <= '0; end
			end
			ST_CK: begin i_q <= '0; jj_q <= '0; end
			ST_CK_D: begin
				gkk_q <= g_rd2;
				acc_q <= 64'(xv_rd);
				s_q <= '0;
			end
			ST_R_A: ;
			ST_R_M: begin
				prod_q <= pfcu_pkg::round_q16(mul_a * mul_b);
				if (jj_q == '0) acc_q <= 64'(xv_rd);
			end
			ST_R_N: begin
				acc_q <= acc_q - prod_q;
				if (!last_jj) jj_q <= jj_q + 1'b1;
			end
			ST_R_X: begin
				jj_q <= '0;
				if (!last_i) i_q <= i_q + 1'b1;
				else i_q <= '0;
			end
			ST_D_R: ;
			ST_D_S: neg_q <= cs_rd[46];
			ST_D_U: if (div_done)
				unew_q <= (nonneg_q && u_sat[31]) ? 32'sd0 : u_sat;
			ST_D_W: begin
				s_q <= s_q + 64'(sq_term);
				if (!last_i) i_q <= i_q + 1'b1;
				else i_q <= '0;
			end
			ST_NORM: begin
				e_q <= '0;
				sq_b_q <= 64'd1 << 62;
				sq_r_q <= '0;
				sq_x_q <= s_q;
			end
			ST_SQ: begin
				if (e_q != 6'h3F && sq_x_q >= (64'd1 << 46)) begin
					sq_x_q <= sq_x_q >> 2;
					e_q <= e_q + 6'd1;
				end else if (e_q != 6'h3F) begin
					sq_x_q <= sq_x_q << 16;
					e_q <= e_q | 6'h20;
				end else if (sq_b_q > sq_x_q && sq_r_q == 64'd0) begin
					sq_b_q <= sq_b_q >> 2;
				end else if (sq_b_q != 64'd0) begin
					if (sq_x_q >= sq_t) begin
						sq_x_q <= sq_x_q - sq_t;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
				end
				if (sq_b_q == 64'd0) nrm_q <= sq_r_q << nrm_q[5:0];
				if (e_q != 6'h3F && sq_x_q < (64'd1 << 46)) begin
					nrm_q <= 64'(e_q[4:0]);
					e_q <= 6'h3F;
				end
			end
			ST_P_A, ST_P_S: ;
			ST_P_W: begin
				if (div_done) begin
					if (!last_i) i_q <= i_q + 1'b1;
					else i_q <= '0;
				end
			end
			ST_NEXT: begin
				i_q <= '0;
				if (last_k) begin k_q <= '0; sw_q <= sw_q + 8'd1; end
				else k_q <= k_q + 1'b1;
			end
			ST_DONE: begin
				rsp.payload.factor_value <= '0;
				rsp.payload.saturated <= sat_q;
			end
			default: ;
		endcase
	end
endmodule

/* bench/projected_factor_column_update_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projected_factor_column_update_unit_tb
// Self-checking bench for the projected factor column update unit.
// ----------------------------------------------------------------------------
// Loads V, X and U through the request channel, runs the column update under
// a range of sweep, sign and size settings, and reads U back. A predictor in
// the scoreboard class mirrors the stores and the fixed point arithmetic and
// queues the expected results; every result transfer is checked against the
// oldest one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module projected_factor_column_update_unit_tb;
	import pfcu_pkg::*;

	localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
	localparam longint     SAT_LIMIT        = 64'sd2147483647;
	localparam longint     RESID_LIMIT      = (64'sd1 <<< 46) - 1;
	localparam longint     ONE_Q            = 64'sd65536;

	class factor_update_predictor;
		int      v_mem[MAX_FEATURES*MAX_RANK];
		int      x_mem[MAX_ROWS*MAX_FEATURES];
		int      u_mem[MAX_ROWS*MAX_RANK];
		int      xv_mem[MAX_ROWS*MAX_RANK];
		int      gram[MAX_RANK*MAX_RANK];
		bit      u_written[MAX_ROWS*MAX_RANK];
		bit      sat_seen;
		int      sweeps, nonneg, rows, feats, rank;
		rsp_t    pending_responses[$];
		int      errors;
		int      checked;

		function new();
			sweeps = 5;
			nonneg = 0;
			rows   = 64;
			feats  = 64;
			rank   = 8;
		endfunction

		function void set_reg(logic [2:0] idx, logic [7:0] d);
			case (idx)
				CFG_SWEEPS:   sweeps = d;
				CFG_NONNEG:   nonneg = d[0];
				CFG_ROWS:     rows   = d[6:0];
				CFG_FEATURES: feats  = d[6:0];
				CFG_RANK:     rank   = d[3:0];
				default: ;
			endcase
		endfunction

		function longint rnd_q16(longint a);
			return (a + 64'sd32768) >>> 16;
		endfunction

		function longint clip(longint a, longint lim);
			if (a > lim) begin
				sat_seen = 1;
				return lim;
			end
			if (a < -lim - 1) begin
				sat_seen = 1;
				return -lim - 1;
			end
			return a;
		endfunction

		function longint div_near(longint num, longint den);
			longint unsigned mag, q;
			mag = (num < 0) ? longint'(-num) : num;
			q = (mag + longint'(den) / 2) / longint'(den);
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		function longint unsigned int_sqrt(longint unsigned a);
			longint unsigned root, b;
			root = 0;
			b = 64'd1 << 62;
			while (b > a)
				b = b >> 2;
			while (b != 0) begin
				if (a >= root + b) begin
					a = a - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function int eff(int val, int lim);
			if (val == 0)
				return 1;
			return (val > lim) ? lim : val;
		endfunction

		function void update_column(int k, int n, int r);
			longint gkk, t, stp, uu;
			longint unsigned s, m, nrm;
			int e;
			longint resid[MAX_ROWS];
			gkk = gram[k*MAX_RANK+k];
			s = 0;
			for (int i = 0; i < n; i++) begin
				t = xv_mem[i*MAX_RANK+k];
				for (int j = 0; j < r; j++)
					t -= rnd_q16(longint'(u_mem[i*MAX_RANK+j]) * longint'(gram[j*MAX_RANK+k]));
				resid[i] = clip(t, RESID_LIMIT);
			end
			for (int i = 0; i < n; i++) begin
				stp = div_near(resid[i] * ONE_Q, gkk);
				uu = clip(longint'(u_mem[i*MAX_RANK+k]) + stp, SAT_LIMIT);
				if (nonneg != 0 && uu < 0)
					uu = 0;
				u_mem[i*MAX_RANK+k] = int'(uu);
				s += longint'(rnd_q16(uu * uu));
			end
			if (s > ONE_Q) begin
				m = s;
				e = 0;
				while (m >= (64'd1 << 46)) begin
					m = m >> 2;
					e++;
				end
				nrm = int_sqrt(m << 16) << e;
				for (int i = 0; i < n; i++) begin
					uu = u_mem[i*MAX_RANK+k];
					u_mem[i*MAX_RANK+k] = int'(clip(div_near(uu * ONE_Q, longint'(nrm)),
						SAT_LIMIT));
				end
			end
		endfunction

		function void run_update();
			int n, p, r;
			longint acc;
			n = eff(rows, MAX_ROWS);
			p = eff(feats, MAX_FEATURES);
			r = eff(rank, MAX_RANK);
			sat_seen = 0;
			for (int i = 0; i < n; i++)
				for (int k = 0; k < r; k++) begin
					acc = 0;
					for (int j = 0; j < p; j++)
						acc += rnd_q16(longint'(x_mem[i*MAX_FEATURES+j]) *
							longint'(v_mem[j*MAX_RANK+k]));
					xv_mem[i*MAX_RANK+k] = int'(clip(acc, SAT_LIMIT));
				end
			for (int j = 0; j < r; j++)
				for (int k = 0; k < r; k++) begin
					acc = 0;
					for (int i = 0; i < p; i++)
						acc += rnd_q16(longint'(v_mem[i*MAX_RANK+j]) *
							longint'(v_mem[i*MAX_RANK+k]));
					gram[j*MAX_RANK+k] = int'(clip(acc, SAT_LIMIT));
				end
			for (int sw = 0; sw < sweeps; sw++)
				for (int k = 0; k < r; k++)
					if (gram[k*MAX_RANK+k] > 0)
						update_column(k, n, r);
		endfunction

		function void note_request(req_t q);
			rsp_t e;
			int row, col;
			row = q.row_index;
			col = q.col_index;
			case (q.req_type)
				REQ_LOAD_V: if (col < MAX_RANK)
					v_mem[row*MAX_RANK+col] = q.element_value;
				REQ_LOAD_X: x_mem[row*MAX_FEATURES+col] = q.element_value;
				REQ_LOAD_U: if (col < MAX_RANK) begin
					u_mem[row*MAX_RANK+col] = q.element_value;
					u_written[row*MAX_RANK+col] = 1;
				end
				REQ_RUN: begin
					run_update();
					e.result_kind = RESULT_RUN;
					e.factor_value = 0;
					e.saturated = sat_seen;
					pending_responses.push_back(e);
				end
				REQ_READ_U: begin
					e.result_kind = RESULT_READ;
					e.factor_value = (col < MAX_RANK) ? u_mem[row*MAX_RANK+col] : 0;
					e.saturated = sat_seen;
					pending_responses.push_back(e);
				end
				default: ;
			endcase
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			checked++;
			if (pending_responses.size() == 0) begin
				$display("%0t: result with none expected: kind %0d value %0d sat %0d",
					$time, a.result_kind, a.factor_value, a.saturated);
				errors++;
				return;
			end
			e = pending_responses.pop_front();
			if (a.result_kind !== e.result_kind) begin
				$display("%0t: result_kind expected %0d actual %0d",
					$time, e.result_kind, a.result_kind);
				errors++;
			end
			if (a.factor_value !== e.factor_value) begin
				$display("%0t: factor_value expected %0d actual %0d",
					$time, e.factor_value, a.factor_value);
				errors++;
			end
			if (a.saturated !== e.saturated) begin
				$display("%0t: saturated expected %0d actual %0d",
					$time, e.saturated, a.saturated);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	pfcu_req_if req_ch();
	pfcu_rsp_if rsp_ch();

	projected_factor_column_update_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	factor_update_predictor board = new();
	int  items_sent;
	int  runs_sent;
	int  reads_sent;
	bit  calm_tx;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int pick_gap();
		int sel;
		if (calm_tx)
			return 0;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_val();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return int'($urandom_range(0, 262144)) - 131072;
		if (sel < 8)
			return int'($urandom_range(0, 512)) - 256;
		return $urandom;
	endfunction

	task automatic send_req(input logic [2:0] kind, input int row, input int col,
		input int val);
		req_t q;
		int g;
		q.req_type = kind;
		q.row_index = row;
		q.col_index = col;
		q.element_value = val;
		g = pick_gap();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= q;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(q);
		if (kind == REQ_RUN)
			runs_sent++;
		if (kind == REQ_READ_U)
			reads_sent++;
		if (kind <= REQ_READ_U && !((kind == REQ_LOAD_V || kind == REQ_LOAD_U) &&
			col >= MAX_RANK))
			items_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_responses.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic apply_config(input int sw, input int nn, input int rows, input int feats,
		input int rank);
		int vals[5];
		vals = '{sw, nn, rows, feats, rank};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= vals[i][7:0];
			@(posedge clk);
			board.set_reg(i[2:0], vals[i][7:0]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic noise_item();
		int row, col;
		row = $urandom_range(0, 63);
		col = $urandom_range(0, MAX_RANK - 1);
		case ($urandom_range(0, 5))
			0: send_req($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST), row,
				$urandom_range(0, 63), $urandom);
			1: send_req(REQ_LOAD_V, row, $urandom_range(MAX_RANK, 63), $urandom);
			2: send_req(REQ_LOAD_U, row, $urandom_range(MAX_RANK, 63), $urandom);
			3: send_req(REQ_READ_U, row, $urandom_range(MAX_RANK, 63), $urandom);
			4: if (board.u_written[row*MAX_RANK+col])
				send_req(REQ_READ_U, row, col, $urandom);
			else
				send_req(REQ_READ_U, row, $urandom_range(MAX_RANK, 63), $urandom);
			default: send_req(REQ_LOAD_X, row, $urandom_range(0, 63), $urandom);
		endcase
	endtask

	task automatic run_phase(input int sw, input int nn, input int rows, input int feats,
		input int rank, input int nruns);
		int n, p, r, pick;
		logic [2:0] todo_kind[$];
		int todo_row[$];
		int todo_col[$];
		drain();
		apply_config(sw, nn, rows, feats, rank);
		calm_tx = ($urandom_range(0, 3) == 0);
		n = board.eff(rows, MAX_ROWS);
		p = board.eff(feats, MAX_FEATURES);
		r = board.eff(rank, MAX_RANK);
		for (int i = 0; i < p; i++)
			for (int k = 0; k < r; k++) begin
				todo_kind.push_back(REQ_LOAD_V);
				todo_row.push_back(i);
				todo_col.push_back(k);
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < p; j++) begin
				todo_kind.push_back(REQ_LOAD_X);
				todo_row.push_back(i);
				todo_col.push_back(j);
			end
		for (int i = 0; i < n; i++)
			for (int k = 0; k < r; k++) begin
				todo_kind.push_back(REQ_LOAD_U);
				todo_row.push_back(i);
				todo_col.push_back(k);
			end
		while (todo_kind.size() > 0) begin
			if ($urandom_range(0, 6) == 0)
				noise_item();
			pick = $urandom_range(0, todo_kind.size() - 1);
			send_req(todo_kind[pick], todo_row[pick], todo_col[pick], pick_val());
			todo_kind.delete(pick);
			todo_row.delete(pick);
			todo_col.delete(pick);
		end
		repeat (nruns) begin
			send_req(REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
			repeat ($urandom_range(1, 4))
				send_req(REQ_READ_U, $urandom_range(0, n - 1), $urandom_range(0, r - 1),
					$urandom);
			noise_item();
			if ($urandom_range(0, 1) == 0)
				send_req(REQ_LOAD_U, $urandom_range(0, n - 1), $urandom_range(0, r - 1),
					pick_val());
		end
	endtask

	function automatic int pick_size(input int lim);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 0;
		return $urandom_range(1, (lim < 6) ? lim : 6);
	endfunction

	initial begin
		int stall_left;
		bit calm_rx;
		rsp_ch.ready <= 1'b0;
		stall_left = 0;
		calm_rx = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				board.check_result(rsp_ch.payload);
			if ($urandom_range(0, 199) == 0)
				calm_rx = ~calm_rx;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm_rx && $urandom_range(0, 5) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int sw;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SWEEPS;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		calm_tx = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_config(0, 0, 1, 1, 1);
		send_req(REQ_LOAD_V, 0, 0, 32'h7fffffff);
		send_req(REQ_LOAD_X, 0, 0, 32'h80000000);
		send_req(REQ_LOAD_U, 0, 0, 32'hffffffff);
		send_req(REQ_LOAD_V, 63, 63, 32'h12345678);
		send_req(REQ_LOAD_U, 63, MAX_RANK, 32'h5a5a5a5a);
		send_req(REQ_LOAD_X, 63, 63, 32'h5555aaaa);
		send_req(REQ_LOAD_V, 0, 1, 0);
		send_req(REQ_LOAD_U, 0, 1, 32'h00010000);
		for (int t = REQ_UNUSED_FIRST; t <= REQ_UNUSED_LAST; t++)
			send_req(t[2:0], 42, 21, 32'hffffffff);
		send_req(REQ_READ_U, 0, 63, 0);
		send_req(REQ_READ_U, 0, 0, 0);
		send_req(REQ_RUN, 0, 0, 0);
		send_req(REQ_READ_U, 0, 0, 0);
		drain();
		// Rank two with an all-zero second V column leaves that column alone.
		apply_config(255, 1, 1, 1, 2);
		send_req(REQ_RUN, 0, 0, 0);
		send_req(REQ_READ_U, 0, 0, 0);
		send_req(REQ_READ_U, 0, 1, 0);
		send_req(REQ_LOAD_V, 0, 0, 32'h00008000);
		send_req(REQ_LOAD_X, 0, 0, 32'h00010000);
		send_req(REQ_RUN, 0, 0, 0);
		send_req(REQ_READ_U, 0, 0, 0);

		run_phase(255, 0, 0, 127, 1, 1);
		run_phase(1, 1, 127, 0, 1, 1);
		run_phase(2, 0, 1, 1, 15, 2);
		run_phase(1, 0, 2, MAX_FEATURES, 2, 1);

		while (items_sent < 550) begin
			sw = $urandom_range(0, 19);
			sw = (sw < 3) ? 0 : (sw < 17) ? $urandom_range(1, 3) : $urandom_range(4, 8);
			run_phase(sw, $urandom_range(0, 1), pick_size(MAX_ROWS),
				pick_size(MAX_FEATURES), pick_size(4), $urandom_range(1, 2));
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_responses.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests including %0d runs and %0d reads of U.",
			items_sent, runs_sent, reads_sent);
		$display("Checked %0d results over extreme and random sizes.", board.checked);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/pfcu_pkg.sv
rtl/core/pfcu_if.sv
rtl/core/pfcu_divider.sv
rtl/core/projected_factor_column_update_unit.sv
bench/projected_factor_column_update_unit_tb.sv
